// ===== hw/rtl/rbst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_pkg: shared types and helpers for the ray/box slab test
// Q16.16 types, configuration register indexes, reset constants and the
// saturation helpers used by the datapath.
// ----------------------------------------------------------------------------
package rbst_pkg;

    localparam int unsigned NUM_AXES = 3;

    typedef logic signed [31:0] q16_t;

    // Configuration register indexes
    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X    = 3'd3;
    localparam logic [2:0] REG_DIR_Y    = 3'd4;
    localparam logic [2:0] REG_DIR_Z    = 3'd5;
    localparam logic [2:0] REG_LENGTH   = 3'd6;

    localparam q16_t Q16_MAX = 32'sh7FFF_FFFF;
    localparam q16_t Q16_MIN = 32'sh8000_0000;
    localparam q16_t Q16_ONE = 32'sh0001_0000;

    localparam logic [30:0] LENGTH_RESET = 31'h7FFF_FFFF;

    // Reset reciprocals: 1/1.0 on x, zero direction gives the largest value
    localparam q16_t INV_X_RESET  = Q16_ONE;
    localparam q16_t INV_YZ_RESET = Q16_MAX;

    // Register load strobes for the per-axis pipeline stages
    typedef struct packed {
        logic corner;
        logic diff;
        logic prod;
        logic slab;
    } stage_load_t;

    function automatic q16_t sat33(input logic signed [32:0] v);
        q16_t r;
        if (v[32] != v[31])
        begin
            r = v[32] ? Q16_MIN : Q16_MAX;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Product >> 16 (floor) and saturate to 32 bits
    function automatic q16_t sat_shift16(input logic signed [63:0] p);
        logic signed [47:0] s;
        q16_t               r;
        s = p[63:16];
        if (s[47:31] == {17{s[47]}})
        begin
            r = s[31:0];
        end
        else
        begin
            r = s[47] ? Q16_MIN : Q16_MAX;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rbst_recip.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_recip: bit-serial Q16.16 reciprocal
// Computes 2^32 / d truncated toward zero, saturated to 32 bits signed, one
// quotient bit per cycle (33 iterations). A zero divisor gives the largest
// positive value.
// ----------------------------------------------------------------------------
module rbst_recip (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire rbst_pkg::q16_t      divisor,
    output logic                     busy,
    output logic                     done,
    output rbst_pkg::q16_t           result
);

    localparam logic [5:0] QUO_MSB = 6'd32;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic [31:0]          rem_reg, rem_next;
    logic [32:0]          quo_reg, quo_next;
    logic [31:0]          mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic                 zero_reg, zero_next;
    rbst_pkg::q16_t       result_reg, result_next;

    logic                 bit_in;
    logic [32:0]          rem_sh;
    logic [32:0]          rem_sub;
    logic                 ge;
    logic [32:0]          quo_step;
    rbst_pkg::q16_t       final_val;

    always_comb
    begin
        bit_in   = (cnt_reg == QUO_MSB);
        rem_sh   = {rem_reg, bit_in};
        ge       = (rem_sh >= {1'b0, mag_reg});
        rem_sub  = rem_sh - {1'b0, mag_reg};
        quo_step = {quo_reg[31:0], ge};

        if (zero_reg)
        begin
            final_val = rbst_pkg::Q16_MAX;
        end
        else if (!neg_reg)
        begin
            final_val = quo_step[32] || quo_step[31] ? rbst_pkg::Q16_MAX
                                                     : rbst_pkg::q16_t'(quo_step[31:0]);
        end
        else if (quo_step > 33'h0_8000_0000)
        begin
            final_val = rbst_pkg::Q16_MIN;
        end
        else
        begin
            final_val = rbst_pkg::q16_t'(~quo_step[31:0] + 32'd1);
        end
    end

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        zero_next   = zero_reg;
        result_next = result_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = QUO_MSB;
            rem_next  = '0;
            quo_next  = '0;
            mag_next  = divisor[31] ? (~divisor + 32'd1) : divisor;
            neg_next  = divisor[31];
            zero_next = (divisor == '0);
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_sub[31:0] : rem_sh[31:0];
            quo_next = quo_step;
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == '0)
            begin
                busy_next   = 1'b0;
                done_next   = 1'b1;
                result_next = final_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        zero_reg   <= zero_next;
        result_reg <= result_next;
    end

    // busy covers the cycle in which the result is handed over
    assign busy   = busy_reg | done_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/rbst_axis.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_axis: per-axis slab pipeline
// Four register stages: box corners, corner minus origin, products with the
// reciprocal direction, then shift/saturate and the near/far slab values.
// ----------------------------------------------------------------------------
module rbst_axis (
    input  wire logic                  clk,
    input  wire rbst_pkg::stage_load_t load,
    input  wire rbst_pkg::q16_t        center,
    input  wire logic [29:0]           half,
    input  wire rbst_pkg::q16_t        origin,
    input  wire rbst_pkg::q16_t        inv,
    output rbst_pkg::q16_t             t_near,
    output rbst_pkg::q16_t             t_far
);

    rbst_pkg::q16_t     lo_reg, lo_next, hi_reg, hi_next;
    rbst_pkg::q16_t     dlo_reg, dlo_next, dhi_reg, dhi_next;
    logic signed [63:0] plo_reg, plo_next, phi_reg, phi_next;
    rbst_pkg::q16_t     tn_reg, tn_next, tx_reg, tx_next;

    rbst_pkg::q16_t     t1, t2;

    always_comb
    begin
        lo_next  = rbst_pkg::sat33({center[31], center} - {3'b000, half});
        hi_next  = rbst_pkg::sat33({center[31], center} + {3'b000, half});
        dlo_next = rbst_pkg::sat33({lo_reg[31], lo_reg} - {origin[31], origin});
        dhi_next = rbst_pkg::sat33({hi_reg[31], hi_reg} - {origin[31], origin});
        plo_next = dlo_reg * inv;
        phi_next = dhi_reg * inv;
        t1       = rbst_pkg::sat_shift16(plo_reg);
        t2       = rbst_pkg::sat_shift16(phi_reg);
        tn_next  = (t1 < t2) ? t1 : t2;
        tx_next  = (t1 < t2) ? t2 : t1;
    end

    always_ff @(posedge clk)
    begin
        if (load.corner)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
        if (load.diff)
        begin
            dlo_reg <= dlo_next;
            dhi_reg <= dhi_next;
        end
        if (load.prod)
        begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
        end
        if (load.slab)
        begin
            tn_reg <= tn_next;
            tx_reg <= tx_next;
        end
    end

    assign t_near = tn_reg;
    assign t_far  = tx_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/ray_box_slab_test_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ray_box_slab_test_core: ray against axis-aligned box, slab test
// Streams boxes (center, half extents) against one configured ray; returns a
// hit flag per box; ray, centers signed Q16.16; half extents unsigned Q14.16.
// ----------------------------------------------------------------------------
// Usage: one box request is taken every cycle while in_ready is high; its hit
// flag is registered through the pipeline stages (corners, differences,
// products, slab min/max, combine), with each pipeline stage holding under
// output back-pressure. Writing a direction register starts a bit-serial
// reciprocal for that axis; in_ready stays low after the write cycle through
// the quotient and the result handoff, at whose end the reciprocal is loaded.
// in_ready is also low in any cycle with cfg_write high. Origin and length
// writes take effect at once; change configuration only with no request in
// flight.
module ray_box_slab_test_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_write,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [31:0]   box_center_x,
    input  wire logic signed [31:0]   box_center_y,
    input  wire logic signed [31:0]   box_center_z,
    input  wire logic [29:0]          box_half_x,
    input  wire logic [29:0]          box_half_y,
    input  wire logic [29:0]          box_half_z,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      hit
);

    localparam int unsigned STAGES = 5;

    rbst_pkg::q16_t         origin_reg [rbst_pkg::NUM_AXES];
    rbst_pkg::q16_t         dir_reg    [rbst_pkg::NUM_AXES];
    rbst_pkg::q16_t         inv_reg    [rbst_pkg::NUM_AXES];
    logic [30:0]            length_reg;

    rbst_pkg::q16_t         center     [rbst_pkg::NUM_AXES];
    logic [29:0]            half       [rbst_pkg::NUM_AXES];
    rbst_pkg::q16_t         t_near     [rbst_pkg::NUM_AXES];
    rbst_pkg::q16_t         t_far      [rbst_pkg::NUM_AXES];

    logic [rbst_pkg::NUM_AXES-1:0] recip_start, recip_busy_vec, recip_done;
    rbst_pkg::q16_t         recip_result [rbst_pkg::NUM_AXES];
    logic                   recip_busy;

    logic [STAGES-1:0]      vld_reg, vld_next;
    logic [STAGES-1:0]      rdy;
    logic                   accept;
    rbst_pkg::stage_load_t  load;
    logic                   load_out;

    rbst_pkg::q16_t         enter_val, leave_val;
    logic                   hit_reg, hit_next;

    assign center[0] = box_center_x;
    assign center[1] = box_center_y;
    assign center[2] = box_center_z;
    assign half[0]   = box_half_x;
    assign half[1]   = box_half_y;
    assign half[2]   = box_half_z;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            dir_reg[0]    <= rbst_pkg::Q16_ONE;
            dir_reg[1]    <= '0;
            dir_reg[2]    <= '0;
            length_reg    <= rbst_pkg::LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rbst_pkg::REG_ORIGIN_X: origin_reg[0] <= cfg_data;
                rbst_pkg::REG_ORIGIN_Y: origin_reg[1] <= cfg_data;
                rbst_pkg::REG_ORIGIN_Z: origin_reg[2] <= cfg_data;
                rbst_pkg::REG_DIR_X:    dir_reg[0]    <= cfg_data;
                rbst_pkg::REG_DIR_Y:    dir_reg[1]    <= cfg_data;
                rbst_pkg::REG_DIR_Z:    dir_reg[2]    <= cfg_data;
                rbst_pkg::REG_LENGTH:   length_reg    <= cfg_data[30:0];
                default:                ;
            endcase
        end
    end

    assign recip_start[0] = cfg_write && (cfg_index == rbst_pkg::REG_DIR_X);
    assign recip_start[1] = cfg_write && (cfg_index == rbst_pkg::REG_DIR_Y);
    assign recip_start[2] = cfg_write && (cfg_index == rbst_pkg::REG_DIR_Z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg[0] <= rbst_pkg::INV_X_RESET;
            inv_reg[1] <= rbst_pkg::INV_YZ_RESET;
            inv_reg[2] <= rbst_pkg::INV_YZ_RESET;
        end
        else
        begin
            for (int a = 0; a < rbst_pkg::NUM_AXES; a++)
            begin
                if (recip_done[a])
                begin
                    inv_reg[a] <= recip_result[a];
                end
            end
        end
    end

    assign recip_busy = |recip_busy_vec;

    // Pipeline flow: a stage takes new data when empty or when it moves on
    always_comb
    begin
        rdy[STAGES-1] = ~vld_reg[STAGES-1] | out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = ~vld_reg[k] | rdy[k+1];
        end
    end

    assign in_ready = rdy[0] & ~recip_busy & ~cfg_write;
    assign accept   = in_valid & in_ready;

    always_comb
    begin
        vld_next[0] = rdy[0] ? accept : vld_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
        load.corner = accept;
        load.diff   = rdy[1] & vld_reg[0];
        load.prod   = rdy[2] & vld_reg[1];
        load.slab   = rdy[3] & vld_reg[2];
        load_out    = rdy[4] & vld_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    for (genvar a = 0; a < rbst_pkg::NUM_AXES; a++)
    begin : g_axis
        // divisor is taken from the write data, in the same cycle as the start
        rbst_recip u_recip (
            .clk     (clk),
            .rst_n   (rst_n),
            .start   (recip_start[a]),
            .divisor (cfg_data),
            .busy    (recip_busy_vec[a]),
            .done    (recip_done[a]),
            .result  (recip_result[a])
        );

        rbst_axis u_axis (
            .clk     (clk),
            .load    (load),
            .center  (center[a]),
            .half    (half[a]),
            .origin  (origin_reg[a]),
            .inv     (inv_reg[a]),
            .t_near  (t_near[a]),
            .t_far   (t_far[a])
        );
    end

    // Entry is the latest near plane, exit the earliest far plane
    always_comb
    begin
        enter_val = t_near[0];
        leave_val = t_far[0];
        for (int a = 1; a < rbst_pkg::NUM_AXES; a++)
        begin
            if (t_near[a] > enter_val)
            begin
                enter_val = t_near[a];
            end
            if (t_far[a] < leave_val)
            begin
                leave_val = t_far[a];
            end
        end
        hit_next = (enter_val <= leave_val) && !leave_val[31]
                   && (enter_val <= $signed({1'b0, length_reg}));
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            hit_reg <= hit_next;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign hit       = hit_reg;

    a_no_accept_during_recip: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> (!recip_busy && !cfg_write))
        else $error("request accepted while reciprocal in progress");

    a_out_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[STAGES-1] && !out_ready) |=> (vld_reg[STAGES-1] && $stable(hit_reg)))
        else $error("stalled result lost or changed");

    a_mid_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[2] && !rdy[3]) |=> vld_reg[2])
        else $error("stalled pipeline stage dropped its request");

    a_zero_dir_inv_max: assert property (@(posedge clk) disable iff (!rst_n)
        (dir_reg[1] == '0 && !recip_busy) |-> (inv_reg[1] == rbst_pkg::Q16_MAX))
        else $error("zero direction without largest reciprocal");

endmodule
`default_nettype wire
